// ===== sv/alignment_pileup_variant_depth_assert.svh =====
`ifndef ALIGNMENT_PILEUP_VARIANT_DEPTH_ASSERT_SVH
`define ALIGNMENT_PILEUP_VARIANT_DEPTH_ASSERT_SVH

// same-cycle implication
`define APVD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define APVD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/apvd_pkg.sv =====
package apvd_pkg;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int SYM_BITS      = 4;
   localparam int FACTOR_BITS   = 10;
   localparam int IDX_BITS      = 34;

   typedef enum logic [2:0] {
      CMD_START  = 3'd0,
      CMD_BASE   = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_SKIP   = 3'd4,
      CMD_CLIP   = 3'd5,
      CMD_LOAD   = 3'd6,
      CMD_READ   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      REG_WINDOW_OFFSET    = 2'd0,
      REG_MIN_BASE_QUALITY = 2'd1,
      REG_MIN_VAR_DEPTH    = 2'd2,
      REG_REF_RATIO_FACTOR = 2'd3
   } reg_index_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [30:0] position;
      logic        unmapped;
      logic [3:0]  read_base;
      logic [7:0]  base_quality;
      logic [27:0] op_length;
      logic [3:0]  ref_symbol;
      logic        bad_op;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] var_depth;
      logic [15:0] ref_depth;
      logic        candidate;
      logic [30:0] region_start;
      logic [31:0] region_end;
   } rsp_item_type;

   typedef struct packed {
      logic [30:0] window_offset;
      logic [7:0]  min_base_quality;
      logic [15:0] min_var_depth;
      logic [9:0]  ref_ratio_factor;
   } cfg_type;

endpackage

// ===== sv/apvd_csr.sv =====
module apvd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [apvd_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [apvd_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [apvd_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output apvd_pkg::cfg_type                   cfg
);

   localparam logic [30:0] RST_WINDOW_OFFSET    = 31'd0;
   localparam logic [7:0]  RST_MIN_BASE_QUALITY = 8'd20;
   localparam logic [15:0] RST_MIN_VAR_DEPTH    = 16'd4;
   localparam logic [9:0]  RST_REF_RATIO_FACTOR = 10'd199;

   apvd_pkg::cfg_type       cfg_ff, cfg_in;
   apvd_pkg::reg_index_type reg_index;
   logic                    write_hit;

   assign reg_index = apvd_pkg::reg_index_type'(paddr[apvd_pkg::CSR_ADDR_BITS-1:2]);
   assign pready    = 1'b1;
   assign write_hit = psel && penable && pwrite && pready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_hit) begin
         case (reg_index)
            apvd_pkg::REG_WINDOW_OFFSET:    cfg_in.window_offset    = pwdata[30:0];
            apvd_pkg::REG_MIN_BASE_QUALITY: cfg_in.min_base_quality = pwdata[7:0];
            apvd_pkg::REG_MIN_VAR_DEPTH:    cfg_in.min_var_depth    = pwdata[15:0];
            apvd_pkg::REG_REF_RATIO_FACTOR: cfg_in.ref_ratio_factor = pwdata[9:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         apvd_pkg::REG_WINDOW_OFFSET:    prdata = {1'b0, cfg_ff.window_offset};
         apvd_pkg::REG_MIN_BASE_QUALITY: prdata = {24'd0, cfg_ff.min_base_quality};
         apvd_pkg::REG_MIN_VAR_DEPTH:    prdata = {16'd0, cfg_ff.min_var_depth};
         apvd_pkg::REG_REF_RATIO_FACTOR: prdata = {22'd0, cfg_ff.ref_ratio_factor};
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_offset    <= RST_WINDOW_OFFSET;
         cfg_ff.min_base_quality <= RST_MIN_BASE_QUALITY;
         cfg_ff.min_var_depth    <= RST_MIN_VAR_DEPTH;
         cfg_ff.ref_ratio_factor <= RST_REF_RATIO_FACTOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/apvd_store.sv =====
module apvd_store #(
   parameter int DEPTH     = 65536,
   parameter int ADDR_BITS = 16,
   parameter int WORD_BITS = 36
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/apvd_ctrl.sv =====
module apvd_ctrl #(
   parameter int WINDOW_DEPTH = 65536,
   parameter int COUNT_BITS   = 16,
   parameter int ADDR_BITS    = $clog2(WINDOW_DEPTH),
   parameter int WORD_BITS    = 2 * COUNT_BITS + apvd_pkg::SYM_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  apvd_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output apvd_pkg::rsp_item_type rsp_item,
   input  apvd_pkg::cfg_type      cfg,
   output logic                   mem_rd_en,
   output logic [ADDR_BITS-1:0]   mem_rd_addr,
   input  logic [WORD_BITS-1:0]   mem_rd_data,
   output logic                   mem_wr_en,
   output logic [ADDR_BITS-1:0]   mem_wr_addr,
   output logic [WORD_BITS-1:0]   mem_wr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC0,
      ST_UPD0,
      ST_UPD1,
      ST_MUL,
      ST_FIN
   } state_type;

   localparam int          PROD_BITS = COUNT_BITS + apvd_pkg::FACTOR_BITS;
   localparam int          SB        = apvd_pkg::SYM_BITS;
   localparam logic [31:0] DEPTH_MAX = 32'h0000_FFFF;
   localparam logic [30:0] PAD_LO    = 31'd2;
   localparam logic [31:0] PAD_HI    = 32'd3;

   state_type                      state_ff, state_in;
   apvd_pkg::req_item_type         item_ff, item_in;
   logic [31:0]                    cursor_ff, cursor_in;
   logic                           ignore_ff, ignore_in;
   logic [ADDR_BITS-1:0]           clr_addr_ff, clr_addr_in;
   logic [ADDR_BITS-1:0]           addr_ff, addr_in;
   logic                           hit_ff, hit_in;
   logic [1:0]                     status_ff, status_in;
   logic [COUNT_BITS-1:0]          var_ff, var_in;
   logic [COUNT_BITS-1:0]          refd_ff, refd_in;
   logic [PROD_BITS-1:0]           prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   apvd_pkg::rsp_item_type         rsp_item_ff, rsp_item_in;

   logic [31:0]                    acc_base;
   logic [apvd_pkg::IDX_BITS-1:0]  acc_delta;
   logic [apvd_pkg::IDX_BITS-1:0]  acc_idx;
   logic                           acc_hit;
   logic [SB-1:0]                  mem_sym;
   logic [COUNT_BITS-1:0]          mem_var, mem_ref, var_inc, ref_inc;
   logic                           base_is_var;
   logic [31:0]                    var_wide, ref_wide;
   apvd_pkg::rsp_item_type         fin_item;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign mem_sym = mem_rd_data[WORD_BITS-1 -: SB];
   assign mem_var = mem_rd_data[2*COUNT_BITS-1 -: COUNT_BITS];
   assign mem_ref = mem_rd_data[COUNT_BITS-1:0];
   assign var_inc = (&mem_var) ? mem_var : mem_var + COUNT_BITS'(1);
   assign ref_inc = (&mem_ref) ? mem_ref : mem_ref + COUNT_BITS'(1);

   assign base_is_var = (mem_sym != item_ff.read_base) && (mem_sym != '0) &&
                        (item_ff.base_quality > cfg.min_base_quality);

   always_comb begin
      acc_base  = cursor_ff;
      acc_delta = '0;
      if (state_ff == ST_ACC0) begin
         if (item_ff.cmd == apvd_pkg::CMD_LOAD || item_ff.cmd == apvd_pkg::CMD_READ) begin
            acc_base = {1'b0, item_ff.position};
         end
         if (item_ff.cmd == apvd_pkg::CMD_INSERT || item_ff.cmd == apvd_pkg::CMD_DELETE) begin
            acc_delta = '1;
         end
      end else if (item_ff.cmd == apvd_pkg::CMD_DELETE) begin
         acc_delta = {6'd0, item_ff.op_length};
      end
   end

   assign acc_idx     = {2'b00, acc_base} + acc_delta - {3'b000, cfg.window_offset};
   assign acc_hit     = !acc_idx[apvd_pkg::IDX_BITS-1] &&
                        (acc_idx[apvd_pkg::IDX_BITS-2:0] <
                         (apvd_pkg::IDX_BITS-1)'(WINDOW_DEPTH));
   assign mem_rd_addr = acc_idx[ADDR_BITS-1:0];

   assign var_wide = 32'(var_ff);
   assign ref_wide = 32'(refd_ff);

   always_comb begin
      fin_item        = '0;
      fin_item.status = status_ff;
      if (item_ff.cmd == apvd_pkg::CMD_READ) begin
         fin_item.var_depth    = (var_wide > DEPTH_MAX) ? DEPTH_MAX[15:0] : var_wide[15:0];
         fin_item.ref_depth    = (ref_wide > DEPTH_MAX) ? DEPTH_MAX[15:0] : ref_wide[15:0];
         fin_item.candidate    = hit_ff && (var_wide >= 32'(cfg.min_var_depth)) &&
                                 (prod_ff > PROD_BITS'(refd_ff));
         fin_item.region_start = (item_ff.position > PAD_LO) ?
                                 item_ff.position - PAD_LO : '0;
         fin_item.region_end   = {1'b0, item_ff.position} + PAD_HI;
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cursor_in    = cursor_ff;
      ignore_in    = ignore_ff;
      clr_addr_in  = clr_addr_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      var_in       = var_ff;
      refd_in      = refd_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_ff;
      mem_wr_data  = {mem_sym, var_inc, mem_ref};

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == ADDR_BITS'(WINDOW_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in   = req_item;
               status_in = apvd_pkg::STATUS_OK;
               state_in  = ST_ACC0;
            end
         end
         ST_ACC0: begin
            addr_in  = acc_idx[ADDR_BITS-1:0];
            hit_in   = acc_hit;
            state_in = ST_FIN;
            case (item_ff.cmd)
               apvd_pkg::CMD_START: begin
                  cursor_in = {1'b0, item_ff.position};
                  ignore_in = item_ff.unmapped;
               end
               apvd_pkg::CMD_SKIP: begin
                  if (!ignore_ff) begin
                     cursor_in = cursor_ff + {4'd0, item_ff.op_length};
                  end
               end
               apvd_pkg::CMD_CLIP: begin
                  if (!ignore_ff && item_ff.bad_op) begin
                     status_in = apvd_pkg::STATUS_BAD;
                     ignore_in = 1'b1;
                  end
               end
               apvd_pkg::CMD_BASE, apvd_pkg::CMD_INSERT, apvd_pkg::CMD_DELETE: begin
                  if (!ignore_ff) begin
                     mem_rd_en = acc_hit;
                     if (!acc_hit) begin
                        status_in = apvd_pkg::STATUS_RANGE;
                     end
                     state_in = ST_UPD0;
                  end
               end
               default: begin
                  mem_rd_en = acc_hit;
                  if (!acc_hit) begin
                     status_in = apvd_pkg::STATUS_RANGE;
                  end
                  state_in = ST_UPD0;
               end
            endcase
         end
         ST_UPD0: begin
            case (item_ff.cmd)
               apvd_pkg::CMD_BASE: begin
                  mem_wr_en = hit_ff;
                  if (!base_is_var) begin
                     mem_wr_data = {mem_sym, mem_var, ref_inc};
                  end
                  cursor_in = cursor_ff + 32'd1;
                  state_in  = ST_FIN;
               end
               apvd_pkg::CMD_INSERT, apvd_pkg::CMD_DELETE: begin
                  mem_wr_en = hit_ff;
                  mem_rd_en = acc_hit;
                  addr_in   = acc_idx[ADDR_BITS-1:0];
                  hit_in    = acc_hit;
                  if (!acc_hit) begin
                     status_in = apvd_pkg::STATUS_RANGE;
                  end
                  state_in = ST_UPD1;
               end
               apvd_pkg::CMD_LOAD: begin
                  mem_wr_en   = hit_ff;
                  mem_wr_data = {item_ff.ref_symbol, mem_var, mem_ref};
                  state_in    = ST_FIN;
               end
               default: begin
                  var_in   = hit_ff ? mem_var : '0;
                  refd_in  = hit_ff ? mem_ref : '0;
                  state_in = ST_MUL;
               end
            endcase
         end
         ST_UPD1: begin
            mem_wr_en = hit_ff;
            if (item_ff.cmd == apvd_pkg::CMD_DELETE) begin
               cursor_in = cursor_ff + {4'd0, item_ff.op_length};
            end
            state_in = ST_FIN;
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(var_ff) * PROD_BITS'(cfg.ref_ratio_factor);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = fin_item;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      addr_ff     <= addr_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      var_ff      <= var_in;
      refd_ff     <= refd_in;
      prod_ff     <= prod_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cursor_ff    <= '0;
         ignore_ff    <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         ignore_ff    <= ignore_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/alignment_pileup_variant_depth.sv =====
// channel | ports                                  | moves
// --------+----------------------------------------+--------------------------------
// req     | req_valid, req_ready, req_item         | one command per transfer
// rsp     | rsp_valid, rsp_ready, rsp_item         | one result per command
// csr     | psel, penable, pwrite, paddr, pwdata,  | four config registers at 0x0,
//         | prdata, pready                         | 0x4, 0x8, 0xC
//
// One command at a time, in states ACC0 then FIN, plus UPD0 for base and load,
// UPD0, UPD1 for insert and delete, UPD0, MUL for read-out, by the read-modify-write
// on the single counter memory (one read, one write per cycle, registered read data).
// After reset a clearing pass writes WINDOW_DEPTH entries, one per cycle, with
// req_ready low; config writes are taken throughout.
// A result waiting on rsp_ready does not block the next req transfer; the finish
// step of that next command holds until the result register frees up.
module alignment_pileup_variant_depth #(
   parameter int WINDOW_DEPTH = 65536,
   parameter int COUNT_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  apvd_pkg::req_item_type             req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output apvd_pkg::rsp_item_type             rsp_item,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [apvd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [apvd_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [apvd_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   localparam int ADDR_BITS = $clog2(WINDOW_DEPTH);
   localparam int WORD_BITS = 2 * COUNT_BITS + apvd_pkg::SYM_BITS;

   apvd_pkg::cfg_type     cfg;
   logic                  mem_rd_en;
   logic [ADDR_BITS-1:0]  mem_rd_addr;
   logic [WORD_BITS-1:0]  mem_rd_data;
   logic                  mem_wr_en;
   logic [ADDR_BITS-1:0]  mem_wr_addr;
   logic [WORD_BITS-1:0]  mem_wr_data;

   apvd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   apvd_store #(
      .DEPTH     (WINDOW_DEPTH),
      .ADDR_BITS (ADDR_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   apvd_ctrl #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .COUNT_BITS   (COUNT_BITS),
      .ADDR_BITS    (ADDR_BITS),
      .WORD_BITS    (WORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .cfg         (cfg),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

endmodule

// ===== sv/apvd_checker.sv =====
`include "alignment_pileup_variant_depth_assert.svh"

module apvd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input apvd_pkg::rsp_item_type rsp_item
);

   `APVD_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second transfer taken while a command is in flight")

   `APVD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "stalled result dropped or changed")

   `APVD_ASSERT_IMP(a_candidate_depth, clock, reset, rsp_valid && rsp_item.candidate, (rsp_item.var_depth != 16'd0) && (rsp_item.status == apvd_pkg::STATUS_OK), "candidate without variant depth")

   `APVD_ASSERT_IMP(a_region_span, clock, reset, rsp_valid, ((rsp_item.region_end - 32'(rsp_item.region_start)) == 32'd5) || ((rsp_item.region_start == 31'd0) && (rsp_item.region_end <= 32'd5)), "region bounds inconsistent")

   `APVD_ASSERT_IMP(a_clear_after_reset, clock, reset, $past(reset), !req_ready, "command taken during clearing pass")

endmodule

bind alignment_pileup_variant_depth apvd_checker u_apvd_checker (.*);
